// ----- rtl/three_channel_pwm_generator_core_assert.svh -----
// assertion macros used by the pwm generator datapath
// no dependencies; included by tcpg_datapath, the only module that carries assertions
`ifndef THREE_CHANNEL_PWM_GENERATOR_CORE_ASSERT_SVH
`define THREE_CHANNEL_PWM_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define TCPG_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpg assertion failed");

// next-cycle implication, disabled while reset is high
`define TCPG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpg assertion failed");

`endif

// ----- rtl/tcpg_pkg.sv -----
// shared types and constants for the three-channel pwm generator
// no dependencies; imported by all pwm generator modules
package tcpg_pkg;

   // request mode codes
   localparam logic [2:0] MODE_TICK     = 3'd0;
   localparam logic [2:0] MODE_SET_FREQ = 3'd1;
   localparam logic [2:0] MODE_SET_DUTY = 3'd2;
   localparam logic [2:0] MODE_ENABLE   = 3'd3;
   localparam logic [2:0] MODE_DISABLE  = 3'd4;

   // full-scale duty in hundredths of percent
   localparam logic [15:0] DUTY_FULL = 16'd10000;
   localparam int          DUTY_W    = 14;

   // duty scaling: floor(x / 5000) as (x * DUTY_RECIP) >> DUTY_SHIFT,
   // exact for every period times duty product up to 32767 * 10000
   localparam logic [28:0] DUTY_RECIP = 29'd439804652;
   localparam int          DUTY_SHIFT = 41;

   // frequency divider: dividend covers the clock rate
   localparam int DIV_W     = 30;
   localparam int DIV_CNT_W = 5;
   localparam int DIVISOR_W = 16;

   // controller to datapath commands
   typedef struct packed {
      logic take_req;
      logic load_product;
      logic finish;
   } tcpg_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_freq_div;
      logic need_duty_div;
      logic div_done;
      logic rsp_hold;
   } tcpg_status_type;

endpackage

// ----- rtl/three_channel_pwm_generator_core.sv -----
// top level of the three-channel pwm generator
// depends on tcpg_pkg, tcpg_ctrl and tcpg_datapath
//
// Each request yields one response. Tick, enable, disable, unused modes and a
// set frequency with zero frequency load their response when taken, so ticks can
// arrive every clock while responses are taken. Set frequency runs on a restoring
// divider that produces one quotient bit per cycle; set duty captures period
// times duty at intake, scales it by a reciprocal multiply in the multiply state
// and loads the response in the finish state. The block takes no new request
// until the response of a long request is loaded, and a long request waits
// longer while the response register is stalled. A held response blocks new
// requests only while it is stalled.
module three_channel_pwm_generator_core
   import tcpg_pkg::*;
#(
   parameter int CLOCK_HZ   = 40000000,
   parameter int PERIOD_MAX = 32767
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_frequency,
   input  logic [15:0] req_duty_request,
   input  logic [5:0]  req_pin_map,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_pin_levels,
   output logic [14:0] rsp_period_value,
   output logic [1:0]  rsp_prescale_code,
   output logic [15:0] rsp_duty_value,
   output logic        rsp_period_wrap,
   output logic        rsp_bad_request
);

   tcpg_cmd_type    cmd;
   tcpg_status_type status;

   // sequencing
   tcpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // registers and arithmetic
   tcpg_datapath #(
      .CLOCK_HZ   (CLOCK_HZ),
      .PERIOD_MAX (PERIOD_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_frequency     (req_frequency),
      .req_duty_request  (req_duty_request),
      .req_pin_map       (req_pin_map),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pin_levels    (rsp_pin_levels),
      .rsp_period_value  (rsp_period_value),
      .rsp_prescale_code (rsp_prescale_code),
      .rsp_duty_value    (rsp_duty_value),
      .rsp_period_wrap   (rsp_period_wrap),
      .rsp_bad_request   (rsp_bad_request)
   );

endmodule

// ----- rtl/tcpg_divider.sv -----
// restoring divider, one quotient bit per cycle
// depends on tcpg_pkg
module tcpg_divider
   import tcpg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic [DIV_W-1:0]     quotient,
   output logic                 done
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]   shifted;
   logic                 fits;

   // trial subtraction of one step
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? DIVISOR_W'(shifted - {1'b0, divisor_ff})
                         : shifted[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = !busy_ff;

endmodule

// ----- rtl/tcpg_ctrl.sv -----
// controller state machine: request intake and divider sequencing
// depends on tcpg_pkg
module tcpg_ctrl
   import tcpg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  tcpg_status_type status,
   output tcpg_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MULT   = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       take;

   // new requests only in idle and with room in the response register
   assign req_stall = (state_ff != ST_IDLE) || status.rsp_hold;
   assign take      = req_valid && !req_stall;

   always_comb begin
      state_in         = state_ff;
      cmd.take_req     = take;
      cmd.load_product = 1'b0;
      cmd.finish       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (status.need_duty_div) begin
                  state_in = ST_MULT;
               end else if (status.need_freq_div) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_MULT: begin
            cmd.load_product = 1'b1;
            state_in         = ST_FINISH;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.rsp_hold) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/tcpg_datapath.sv -----
// datapath: prescaler, timebase, period and duty registers, response register
// depends on tcpg_pkg, tcpg_divider and the assertion macro header
`include "three_channel_pwm_generator_core_assert.svh"

module tcpg_datapath
   import tcpg_pkg::*;
#(
   parameter int CLOCK_HZ   = 40000000,
   parameter int PERIOD_MAX = 32767
) (
   input  logic            clock,
   input  logic            reset,
   input  tcpg_cmd_type    cmd,
   output tcpg_status_type status,
   input  logic [2:0]      req_mode,
   input  logic [15:0]     req_frequency,
   input  logic [15:0]     req_duty_request,
   input  logic [5:0]      req_pin_map,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [5:0]      rsp_pin_levels,
   output logic [14:0]     rsp_period_value,
   output logic [1:0]      rsp_prescale_code,
   output logic [15:0]     rsp_duty_value,
   output logic            rsp_period_wrap,
   output logic            rsp_bad_request
);

   localparam logic [DIV_W-1:0] CLOCK_DIVIDEND = DIV_W'(CLOCK_HZ);
   localparam logic [DIV_W-1:0] PERIOD_LIMIT   = DIV_W'(PERIOD_MAX);

   // pwm state
   logic [1:0]  presc_sel_ff, presc_sel_in;
   logic [14:0] period_ff, period_in;
   logic [14:0] timebase_ff, timebase_in;
   logic [5:0]  presc_cnt_ff, presc_cnt_in;
   logic [15:0] duty_pending_ff [3];
   logic [15:0] duty_pending_in [3];
   logic [15:0] duty_active_ff [3];
   logic [15:0] duty_active_in [3];
   logic [5:0]  enable_ff, enable_in;
   logic [15:0] last_duty_ff, last_duty_in;

   // request held while a long request runs
   logic              op_duty_ff;
   logic [5:0]        map_ff;
   logic [28:0]       product_ff;
   logic [15:0]       duty_quot_ff;
   logic [DUTY_W-1:0] duty_clamp;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  levels_ff;
   logic [14:0] period_out_ff;
   logic [1:0]  presc_out_ff;
   logic [15:0] duty_out_ff;
   logic        wrap_ff, bad_ff;

   logic                 immediate, load_rsp, wrap_in, bad_in;
   logic                 is_tick, is_freq, is_duty, freq_zero;
   logic                 div_start, div_done;
   logic [DIV_W-1:0]     div_dividend, quotient;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [28:0]          product;
   logic [57:0]          recip_prod;
   logic [6:0]           presc_next, presc_div;
   logic [5:0]           levels_in;
   logic [15:0]          timebase2;
   logic [DIV_W-1:0]     scaled [4];
   logic [DIV_W-1:0]     per_try [4];
   logic [3:0]           per_fit;
   logic [1:0]           sel_code;
   logic [14:0]          sel_period;
   logic [15:0]          duty_result;

   // request decode
   assign is_tick   = req_mode == MODE_TICK;
   assign is_freq   = req_mode == MODE_SET_FREQ;
   assign is_duty   = req_mode == MODE_SET_DUTY;
   assign freq_zero = req_frequency == '0;
   assign immediate = !(is_duty || (is_freq && !freq_zero));
   assign duty_clamp = (req_duty_request > DUTY_FULL) ? DUTY_FULL[DUTY_W-1:0]
                                                      : req_duty_request[DUTY_W-1:0];

   // duty scaling: period times duty at intake, then a reciprocal of 5000
   assign product    = 29'(period_ff) * 29'(duty_clamp);
   assign recip_prod = 58'(product_ff) * 58'(DUTY_RECIP);

   // frequency divider: clock rate over frequency
   assign div_start    = cmd.take_req && is_freq && !freq_zero;
   assign div_dividend = CLOCK_DIVIDEND;
   assign div_divisor  = req_frequency;

   tcpg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   // prescaler search over the four codes, first fit wins
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         scaled[k]  = quotient >> (2 * k);
         per_try[k] = (scaled[k] == '0) ? '0 : scaled[k] - DIV_W'(1);
         per_fit[k] = per_try[k] <= PERIOD_LIMIT;
      end
      sel_code   = 2'd3;
      sel_period = 15'(PERIOD_MAX);
      for (int k = 3; k >= 0; k--) begin
         if (per_fit[k]) begin
            sel_code   = 2'(k);
            sel_period = per_try[k][14:0];
         end
      end
   end

   assign duty_result = duty_quot_ff;
   assign presc_next  = {1'b0, presc_cnt_ff} + 7'd1;
   assign presc_div   = 7'd1 << {presc_sel_ff, 1'b0};

   // next state of the pwm registers
   always_comb begin
      presc_sel_in = presc_sel_ff;
      period_in    = period_ff;
      timebase_in  = timebase_ff;
      presc_cnt_in = presc_cnt_ff;
      enable_in    = enable_ff;
      last_duty_in = last_duty_ff;
      wrap_in      = 1'b0;
      bad_in       = 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
         duty_pending_in[ch] = duty_pending_ff[ch];
         duty_active_in[ch]  = duty_active_ff[ch];
      end
      if (cmd.take_req) begin
         unique case (req_mode)
            MODE_TICK: begin
               if (presc_next < presc_div) begin
                  presc_cnt_in = presc_next[5:0];
               end else begin
                  presc_cnt_in = '0;
                  if (timebase_ff >= period_ff) begin
                     timebase_in = '0;
                     wrap_in     = 1'b1;
                     for (int ch = 0; ch < 3; ch++) begin
                        duty_active_in[ch] = duty_pending_ff[ch];
                     end
                  end else begin
                     timebase_in = timebase_ff + 15'd1;
                  end
               end
            end
            MODE_SET_FREQ: begin
               bad_in = freq_zero;
            end
            MODE_ENABLE: begin
               enable_in = enable_ff | req_pin_map;
            end
            MODE_DISABLE: begin
               enable_in = enable_ff & ~req_pin_map;
            end
            default: begin
            end
         endcase
      end
      // long request result applied at its end
      if (cmd.finish) begin
         if (op_duty_ff) begin
            last_duty_in = duty_result;
            for (int ch = 0; ch < 3; ch++) begin
               if (map_ff[5-2*ch -: 2] != 2'b00) begin
                  duty_pending_in[ch] = duty_result;
               end
            end
         end else begin
            presc_sel_in = sel_code;
            period_in    = sel_period;
         end
      end
   end

   // pin levels from the updated state
   assign timebase2 = {timebase_in, 1'b0};
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         levels_in[5-2*ch -: 2] = {2{timebase2 < duty_active_in[ch]}};
      end
      levels_in = levels_in & enable_in;
   end

   assign load_rsp     = (cmd.take_req && immediate) || cmd.finish;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         presc_sel_ff <= '0;
         period_ff    <= 15'h7FFF;
         timebase_ff  <= '0;
         presc_cnt_ff <= '0;
         enable_ff    <= '0;
         last_duty_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int ch = 0; ch < 3; ch++) begin
            duty_pending_ff[ch] <= '0;
            duty_active_ff[ch]  <= '0;
         end
      end else begin
         presc_sel_ff <= presc_sel_in;
         period_ff    <= period_in;
         timebase_ff  <= timebase_in;
         presc_cnt_ff <= presc_cnt_in;
         enable_ff    <= enable_in;
         last_duty_ff <= last_duty_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int ch = 0; ch < 3; ch++) begin
            duty_pending_ff[ch] <= duty_pending_in[ch];
            duty_active_ff[ch]  <= duty_active_in[ch];
         end
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_duty_ff <= is_duty;
         map_ff     <= req_pin_map;
         product_ff <= product;
      end
      if (cmd.load_product) begin
         duty_quot_ff <= recip_prod[DUTY_SHIFT+15:DUTY_SHIFT];
      end
      if (load_rsp) begin
         levels_ff     <= levels_in;
         period_out_ff <= period_in;
         presc_out_ff  <= presc_sel_in;
         duty_out_ff   <= last_duty_in;
         wrap_ff       <= wrap_in;
         bad_ff        <= bad_in;
      end
   end

   assign status.need_freq_div = is_freq && !freq_zero;
   assign status.need_duty_div = is_duty;
   assign status.div_done      = div_done;
   assign status.rsp_hold      = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_levels    = levels_ff;
   assign rsp_period_value  = period_out_ff;
   assign rsp_prescale_code = presc_out_ff;
   assign rsp_duty_value    = duty_out_ff;
   assign rsp_period_wrap   = wrap_ff;
   assign rsp_bad_request   = bad_ff;

   // checks
   `TCPG_ASSERT_IMPL(a_no_rsp_overwrite, clock, reset, load_rsp, !status.rsp_hold)
   `TCPG_ASSERT_IMPL(a_finish_after_div, clock, reset, cmd.finish, div_done)
   `TCPG_ASSERT_IMPL(a_period_bound, clock, reset, 1'b1, 30'(period_ff) <= PERIOD_LIMIT)
   `TCPG_ASSERT_NEXT(a_wrap_clears_tb, clock, reset, load_rsp && wrap_in, timebase_ff == '0)

endmodule

// ----- tb/pwm_response_checker.sv -----
// response checker for the three-channel pwm generator: predicts and compares responses
// depends on tcpg_pkg for mode codes and the full-scale duty constant
module pwm_response_checker
   import tcpg_pkg::*;
#(
   parameter int CLOCK_HZ   = 40000000,
   parameter int PERIOD_MAX = 32767
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_frequency,
   input  logic [15:0] req_duty_request,
   input  logic [5:0]  req_pin_map,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_pin_levels,
   input  logic [14:0] rsp_period_value,
   input  logic [1:0]  rsp_prescale_code,
   input  logic [15:0] rsp_duty_value,
   input  logic        rsp_period_wrap,
   input  logic        rsp_bad_request,
   output int unsigned mismatch_count,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0]  pin_levels;
      logic [14:0] period;
      logic [1:0]  prescale;
      logic [15:0] duty;
      logic        wrap;
      logic        bad;
   } pwm_report_type;

   // mirrored generator state
   logic [1:0]  prescale_sel;
   logic [14:0] period_reg;
   logic [14:0] timebase;
   logic [5:0]  prescale_cnt;
   logic [15:0] duty_next [3];
   logic [15:0] duty_live [3];
   logic [5:0]  pins_on;
   logic [15:0] duty_last;

   pwm_report_type pending_outputs [$];
   int unsigned faults = 0;

   assign mismatch_count = faults;

   // channel 0 owns bits 5..4, channel 2 bits 1..0
   function automatic logic [5:0] channel_mask(input int ch);
      return 6'b000011 << (4 - 2 * ch);
   endfunction

   // one tick: prescaler first, then timebase with wrap and duty reload
   function automatic logic advance_timebase();
      int divisor;
      divisor = 1 << (2 * prescale_sel);
      if (int'(prescale_cnt) + 1 < divisor) begin
         prescale_cnt = prescale_cnt + 6'd1;
         return 1'b0;
      end
      prescale_cnt = '0;
      if (timebase >= period_reg) begin
         timebase = '0;
         for (int ch = 0; ch < 3; ch++) duty_live[ch] = duty_next[ch];
         return 1'b1;
      end
      timebase = timebase + 15'd1;
      return 1'b0;
   endfunction

   // pick the smallest prescaler whose period fits, clamp if none does
   function automatic void retune(input logic [15:0] freq);
      longint q;
      longint s;
      longint per;
      int     code;
      bit     fit;
      q = longint'(CLOCK_HZ) / longint'(freq);
      per = 0;
      fit = 1'b0;
      for (code = 0; code < 4; code++) begin
         s = q >> (2 * code);
         per = (s == 0) ? 0 : s - 1;
         if (per <= PERIOD_MAX) begin
            fit = 1'b1;
            break;
         end
      end
      if (!fit) begin
         code = 3;
         per = PERIOD_MAX;
      end
      prescale_sel = code[1:0];
      period_reg = per[14:0];
   endfunction

   // scale the saturated duty to the current period
   function automatic void store_duty(input logic [15:0] req, input logic [5:0] map);
      longint d;
      longint v;
      d = (req > DUTY_FULL) ? longint'(DUTY_FULL) : longint'(req);
      v = (2 * longint'(period_reg) * d) / longint'(DUTY_FULL);
      duty_last = v[15:0];
      for (int ch = 0; ch < 3; ch++)
         if ((map & channel_mask(ch)) != 0) duty_next[ch] = v[15:0];
   endfunction

   function automatic logic [5:0] pin_drive();
      logic [5:0] lv;
      lv = '0;
      for (int ch = 0; ch < 3; ch++)
         if ({timebase, 1'b0} < duty_live[ch]) lv = lv | channel_mask(ch);
      return lv & pins_on;
   endfunction

   // apply one request to the mirrored state and report what the block shows after it
   function automatic pwm_report_type apply_request(input logic [2:0] mode,
                                                    input logic [15:0] freq,
                                                    input logic [15:0] duty,
                                                    input logic [5:0] map);
      pwm_report_type r;
      logic           wrap;
      logic           bad;
      wrap = 1'b0;
      bad = 1'b0;
      case (mode)
         MODE_TICK: begin
            wrap = advance_timebase();
         end
         MODE_SET_FREQ: begin
            if (freq == '0) bad = 1'b1;
            else retune(freq);
         end
         MODE_SET_DUTY: begin
            store_duty(duty, map);
         end
         MODE_ENABLE: begin
            pins_on = pins_on | map;
         end
         MODE_DISABLE: begin
            pins_on = pins_on & ~map;
         end
         default: ;
      endcase
      r.pin_levels = pin_drive();
      r.period = period_reg;
      r.prescale = prescale_sel;
      r.duty = duty_last;
      r.wrap = wrap;
      r.bad = bad;
      return r;
   endfunction

   // watch both channels; a request is predicted before a response is matched
   always @(posedge clock) begin
      pwm_report_type seen;
      pwm_report_type want;
      logic           bad_field;
      if (reset) begin
         prescale_sel = '0;
         period_reg = 15'd32767;
         timebase = '0;
         prescale_cnt = '0;
         for (int ch = 0; ch < 3; ch++) begin
            duty_next[ch] = '0;
            duty_live[ch] = '0;
         end
         pins_on = '0;
         duty_last = '0;
         pending_outputs.delete();
      end else begin
         if (req_valid && !req_stall)
            pending_outputs.push_back(apply_request(req_mode, req_frequency,
                                                    req_duty_request, req_pin_map));
         if (rsp_valid && !rsp_stall) begin
            seen.pin_levels = rsp_pin_levels;
            seen.period = rsp_period_value;
            seen.prescale = rsp_prescale_code;
            seen.duty = rsp_duty_value;
            seen.wrap = rsp_period_wrap;
            seen.bad = rsp_bad_request;
            if (pending_outputs.size() == 0) begin
               if (faults < 10)
                  $display("%0t: response with no request outstanding: pins %h period %0d",
                           $realtime, seen.pin_levels, seen.period);
               faults++;
            end else begin
               want = pending_outputs.pop_front();
               bad_field = (seen.pin_levels !== want.pin_levels)
                         | (seen.period !== want.period)
                         | (seen.prescale !== want.prescale)
                         | (seen.duty !== want.duty)
                         | (seen.wrap !== want.wrap)
                         | (seen.bad !== want.bad);
               if (bad_field) begin
                  if (faults < 10) begin
                     $display("%0t: exp pins %h period %0d code %0d duty %0d wrap %b bad %b",
                              $realtime, want.pin_levels, want.period, want.prescale,
                              want.duty, want.wrap, want.bad);
                     $display("%0t: got pins %h period %0d code %0d duty %0d wrap %b bad %b",
                              $realtime, seen.pin_levels, seen.period, seen.prescale,
                              seen.duty, seen.wrap, seen.bad);
                  end
                  faults++;
               end
            end
         end
      end
      outstanding <= pending_outputs.size();
   end

endmodule

// ----- tb/tb_three_channel_pwm_generator_core.sv -----
// testbench top for the three-channel pwm generator: clock, reset, request and stall stimulus
// depends on tcpg_pkg, three_channel_pwm_generator_core and pwm_response_checker
module tb_three_channel_pwm_generator_core
   import tcpg_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // modes the block decodes to nothing
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = MODE_TICK;
   logic [15:0] req_frequency = '0;
   logic [15:0] req_duty_request = '0;
   logic [5:0]  req_pin_map = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_pin_levels;
   logic [14:0] rsp_period_value;
   logic [1:0]  rsp_prescale_code;
   logic [15:0] rsp_duty_value;
   logic        rsp_period_wrap;
   logic        rsp_bad_request;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned quiet_cycles = 0;
   logic        calm = 1'b0;

   three_channel_pwm_generator_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_frequency    (req_frequency),
      .req_duty_request (req_duty_request),
      .req_pin_map      (req_pin_map),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pin_levels   (rsp_pin_levels),
      .rsp_period_value (rsp_period_value),
      .rsp_prescale_code(rsp_prescale_code),
      .rsp_duty_value   (rsp_duty_value),
      .rsp_period_wrap  (rsp_period_wrap),
      .rsp_bad_request  (rsp_bad_request)
   );

   pwm_response_checker response_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_frequency    (req_frequency),
      .req_duty_request (req_duty_request),
      .req_pin_map      (req_pin_map),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pin_levels   (rsp_pin_levels),
      .rsp_period_value (rsp_period_value),
      .rsp_prescale_code(rsp_prescale_code),
      .rsp_duty_value   (rsp_duty_value),
      .rsp_period_wrap  (rsp_period_wrap),
      .rsp_bad_request  (rsp_bad_request),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // response back-pressure, off during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 19);
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // present one request, with a random gap ahead of it, and hold it until taken
   task automatic send_request(input logic [2:0] mode, input logic [15:0] freq,
                               input logic [15:0] duty, input logic [5:0] map);
      while (!calm && ($urandom_range(0, 99) < 19)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_frequency <= freq;
      req_duty_request <= duty;
      req_pin_map <= map;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [15:0] any16();
      return 16'($urandom);
   endfunction

   function automatic logic [5:0] any_map();
      return 6'($urandom);
   endfunction

   function automatic logic [15:0] pick_duty();
      if ($urandom_range(0, 99) < 15) return 16'($urandom_range(10000, 65535));
      return 16'($urandom_range(0, 10000));
   endfunction

   initial begin
      int unsigned ticks;
      logic [15:0] freq;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, zero frequency, clamp, prescaler shrink, duty extremes
      send_request(MODE_TICK, 16'hFFFF, 16'hFFFF, 6'h3F);
      send_request(MODE_SET_FREQ, 16'd0, any16(), any_map());
      send_request(MODE_SET_FREQ, 16'd1, any16(), any_map());
      repeat (5) send_request(MODE_TICK, any16(), any16(), any_map());
      send_request(MODE_SET_FREQ, 16'd1000, any16(), any_map());
      send_request(MODE_TICK, any16(), any16(), any_map());
      send_request(MODE_SET_FREQ, 16'hFFFF, 16'd0, 6'd0);
      send_request(MODE_SET_DUTY, 16'd0, 16'd0, 6'd0);
      send_request(MODE_SET_DUTY, any16(), 16'hFFFF, 6'h3F);
      send_request(MODE_SET_DUTY, any16(), 16'd10000, 6'b110000);
      send_request(MODE_SET_DUTY, any16(), 16'd10001, 6'b000011);
      send_request(MODE_SET_DUTY, any16(), 16'd5000, 6'b001000);
      send_request(MODE_ENABLE, any16(), any16(), 6'h3F);
      send_request(MODE_DISABLE, any16(), any16(), 6'b010101);
      send_request(MODE_ENABLE, any16(), any16(), 6'b000000);
      send_request(MODE_ENABLE, any16(), any16(), 6'b010101);
      send_request(MODE_SPARE_A, any16(), any16(), any_map());
      send_request(MODE_SPARE_B, any16(), any16(), any_map());
      send_request(MODE_SPARE_C, 16'hFFFF, 16'hFFFF, 6'h3F);
      send_request(MODE_SET_FREQ, 16'd40000, any16(), any_map());

      // random: mostly set frequency, duties, enables, then a short tick run
      for (int seq = 0; seq < 40; seq++) begin
         calm <= (seq >= 14) && (seq < 22);
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 9) < 8) freq = 16'($urandom_range(50000, 65535));
            else freq = 16'($urandom_range(1, 65535));
            send_request(MODE_SET_FREQ, freq, any16(), any_map());
            repeat ($urandom_range(1, 3)) send_request(MODE_SET_DUTY, any16(), pick_duty(),
                                                      any_map());
            send_request(MODE_ENABLE, any16(), any16(), any_map());
            if ($urandom_range(0, 3) == 0)
               send_request(MODE_DISABLE, any16(), any16(), any_map());
            ticks = $urandom_range(3, 11);
            repeat (ticks) begin
               case ($urandom_range(0, 199)) inside
                  [0:1]: send_request(MODE_SET_DUTY, any16(), pick_duty(), any_map());
                  2: send_request(MODE_ENABLE, any16(), any16(), any_map());
                  3: send_request(MODE_DISABLE, any16(), any16(), any_map());
                  4: send_request(MODE_SET_FREQ, 16'($urandom_range(50000, 65535)), any16(),
                                  any_map());
                  default: send_request(MODE_TICK, any16(), any16(), any_map());
               endcase
            end
         end else begin
            // noise: any mode with any fields, zero frequency now and then
            repeat ($urandom_range(3, 12)) begin
               freq = ($urandom_range(0, 3) == 0) ? 16'd0 : any16();
               send_request(3'($urandom_range(0, 7)), freq, any16(), any_map());
            end
         end
      end
      req_valid <= 1'b0;

      // drain, then allow for anything still in flight
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- three_channel_pwm_generator_core.f -----
+incdir+rtl
rtl/tcpg_pkg.sv
rtl/tcpg_divider.sv
rtl/tcpg_ctrl.sv
rtl/tcpg_datapath.sv
rtl/three_channel_pwm_generator_core.sv
tb/pwm_response_checker.sv
tb/tb_three_channel_pwm_generator_core.sv
